// ----- hdl/kesf_pkg.sv -----
// Package for the keyed entry store with oldest-first eviction.
// Field widths, the payload layout, action codes and controller types.
package kesf_pkg;

  localparam int unsigned CapacityDefault = 256;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned MoveW  = 16;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned DepthW = 8;
  localparam int unsigned BoundW = 2;

  typedef enum logic {
    ActProbe  = 1'b0,
    ActInsert = 1'b1
  } action_e;

  // Stored payload: move[41:26] score[25:10] depth[9:2] bound[1:0]
  typedef struct packed {
    logic        [MoveW-1:0]  move;
    logic signed [ScoreW-1:0] score;
    logic        [DepthW-1:0] depth;
    logic        [BoundW-1:0] bound;
  } payload_t;

  localparam int unsigned PayloadW = $bits(payload_t);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StPread  = 5'b00100,
    StResult = 5'b01000,
    StWrite  = 5'b10000
  } state_e;

  // Scan unit status toward the controller
  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

// ----- hdl/kesf_if.sv -----
// Valid/ready channel interfaces for requests and probe results.
// Depends on kesf_pkg for field widths and the action code type.
interface kesf_req_if;
  import kesf_pkg::*;

  logic                     valid;
  logic                     ready;
  action_e                  action;
  logic        [KeyW-1:0]   key;
  logic        [MoveW-1:0]  move_code;
  logic signed [ScoreW-1:0] score;
  logic        [DepthW-1:0] search_depth;
  logic        [BoundW-1:0] bound_kind;

  modport source (
    output valid, action, key, move_code, score, search_depth, bound_kind,
    input  ready
  );
  modport sink (
    input  valid, action, key, move_code, score, search_depth, bound_kind,
    output ready
  );
endinterface

interface kesf_rsp_if;
  import kesf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic        [MoveW-1:0]  found_move;
  logic signed [ScoreW-1:0] found_score;
  logic        [DepthW-1:0] found_depth;
  logic        [BoundW-1:0] found_bound;

  modport source (
    output valid, hit, found_move, found_score, found_depth, found_bound,
    input  ready
  );
  modport sink (
    input  valid, hit, found_move, found_score, found_depth, found_bound,
    output ready
  );
endinterface

// ----- hdl/kesf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module kesf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/kesf_scan.sv -----
// Key scan unit: walks the filled slots of the key RAM one address a cycle
// and compares each returned key. Depends on kesf_pkg.
module kesf_scan #(
  parameter int unsigned Capacity = kesf_pkg::CapacityDefault,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [CW-1:0]           fill_i,
  input  logic [kesf_pkg::KeyW-1:0] key_i,
  output logic                    rd_en_o,
  output logic [AW-1:0]           rd_addr_o,
  input  logic [kesf_pkg::KeyW-1:0] rd_key_i,
  output kesf_pkg::scan_stat_t    stat_o,
  output logic [AW-1:0]           idx_o
);
  import kesf_pkg::*;

  logic          busy_q, busy_d;
  logic          more_q, more_d;
  logic          chk_q, chk_d;
  logic [CW-1:0] addr_q, addr_d;
  logic [CW-1:0] addr_inc;
  logic [AW-1:0] chk_addr_q;
  logic          match;

  assign addr_inc  = addr_q + 1'b1;
  assign match     = chk_q && (rd_key_i == key_i);
  assign rd_en_o   = busy_q && more_q;
  assign rd_addr_o = addr_q[AW-1:0];

  // Finish on a match, or when the last slot has been compared
  assign stat_o.done = busy_q && chk_q && (match || !more_q);
  assign stat_o.hit  = match;
  assign idx_o       = chk_addr_q;

  always_comb begin
    busy_d = busy_q;
    more_d = more_q;
    chk_d  = chk_q;
    addr_d = addr_q;
    if (start_i) begin
      busy_d = 1'b1;
      more_d = 1'b1;
      chk_d  = 1'b0;
      addr_d = '0;
    end else if (busy_q) begin
      chk_d = rd_en_o;
      if (rd_en_o) begin
        addr_d = addr_inc;
        more_d = (addr_inc < fill_i);
      end
      if (stat_o.done) begin
        busy_d = 1'b0;
        chk_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      more_q <= 1'b0;
      chk_q  <= 1'b0;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      more_q <= more_d;
      chk_q  <= chk_d;
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) begin
      chk_addr_q <= rd_addr_o;
    end
  end

  a_read_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> ({1'b0, addr_q} < {1'b0, fill_i}))
    else $error("scan reads a slot beyond the fill count");

  a_done_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> $past(rd_en_o))
    else $error("scan finishes without a key read in the previous cycle");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("scan restarted while busy");

endmodule

// ----- hdl/keyed_entry_store_fifo_evict_unit.sv -----
// Keyed entry store with oldest-first eviction: top level.
// A probe scans the filled slots at one key RAM read per cycle, then on a hit reads the
// payload RAM; the result is loaded into the output register once that is free. An insert
// scans likewise, then writes over the matching slot's payload or appends at the write
// pointer. One item is in work at a time. A result waits in the output register meanwhile.
// Reset clears the fill count and write pointer; RAM contents are not cleared.
module keyed_entry_store_fifo_evict_unit #(
  parameter int unsigned Capacity = kesf_pkg::CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kesf_req_if.sink    req_i,
  kesf_rsp_if.source  rsp_o
);
  import kesf_pkg::*;

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic            hit_q, hit_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic            out_hit_q;
  payload_t        out_pay_q;
  logic            out_load;

  action_e         act_q;
  logic [KeyW-1:0] key_q;
  payload_t        pay_q;

  logic            accept;
  logic            scan_start;
  scan_stat_t      scan_stat;
  logic [AW-1:0]   scan_idx;
  logic            key_re;
  logic [AW-1:0]   key_raddr;
  logic [KeyW-1:0] key_rdata;
  logic            key_we;
  logic            pay_we, pay_re;
  logic [AW-1:0]   pay_waddr;
  logic [PayloadW-1:0] pay_rdata;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;

  kesf_ram #(.Width(KeyW), .Depth(Capacity)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (key_q),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  kesf_ram #(.Width(PayloadW), .Depth(Capacity)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_q),
    .re_i    (pay_re),
    .raddr_i (idx_q),
    .rdata_o (pay_rdata)
  );

  kesf_scan #(.Capacity(Capacity)) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .fill_i    (fill_q),
    .key_i     (key_q),
    .rd_en_o   (key_re),
    .rd_addr_o (key_raddr),
    .rd_key_i  (key_rdata),
    .stat_o    (scan_stat),
    .idx_o     (scan_idx)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wr_ptr_d    = wr_ptr_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_load    = 1'b0;
    scan_start  = 1'b0;
    key_we      = 1'b0;
    pay_we      = 1'b0;
    pay_re      = 1'b0;
    pay_waddr   = wr_ptr_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (fill_q == '0) begin
            // Empty store: miss without scanning
            hit_d   = 1'b0;
            state_d = (req_i.action == ActInsert) ? StWrite : StResult;
          end else begin
            scan_start = 1'b1;
            state_d    = StScan;
          end
        end
      end
      StScan: begin
        if (scan_stat.done) begin
          hit_d = scan_stat.hit;
          idx_d = scan_idx;
          if (act_q == ActInsert) begin
            state_d = StWrite;
          end else if (scan_stat.hit) begin
            state_d = StPread;
          end else begin
            state_d = StResult;
          end
        end
      end
      StPread: begin
        pay_re  = 1'b1;
        state_d = StResult;
      end
      StResult: begin
        // Hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      StWrite: begin
        pay_we = 1'b1;
        if (hit_q) begin
          pay_waddr = idx_q;
        end else begin
          key_we   = 1'b1;
          wr_ptr_d = (wr_ptr_q == AW'(Capacity - 1)) ? '0 : wr_ptr_q + 1'b1;
          if (fill_q != CW'(Capacity)) begin
            fill_d = fill_q + 1'b1;
          end
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      wr_ptr_q    <= '0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wr_ptr_q    <= wr_ptr_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q       <= req_i.action;
      key_q       <= req_i.key;
      pay_q.move  <= req_i.move_code;
      pay_q.score <= req_i.score;
      pay_q.depth <= req_i.search_depth;
      pay_q.bound <= req_i.bound_kind;
    end
    if (out_load) begin
      out_hit_q <= hit_q;
      out_pay_q <= hit_q ? payload_t'(pay_rdata) : '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.found_move  = out_pay_q.move;
  assign rsp_o.found_score = out_pay_q.score;
  assign rsp_o.found_depth = out_pay_q.depth;
  assign rsp_o.found_bound = out_pay_q.bound;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(Capacity))
    else $error("fill count exceeds capacity");

  a_ptr_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != CW'(Capacity)) |-> (CW'(wr_ptr_q) == fill_q))
    else $error("write pointer out of step with fill count while filling");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StResult))
    else $error("result raised outside the result state");

  a_new_key_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> !pay_re && !key_re)
    else $error("key write overlaps a read");

endmodule
